>>> rtl/core/ucdc_pkg.sv
// Shared types, request codes, descriptor table and sequencer program for the CDC control handler.
package ucdc_pkg;

  localparam logic [6:0] EP0_PACKET_BYTES = 7'd8;

  // Reply kinds.
  localparam logic [2:0] KIND_STALL  = 3'd0;
  localparam logic [2:0] KIND_DATA   = 3'd1;
  localparam logic [2:0] KIND_STATUS = 3'd2;
  localparam logic [2:0] KIND_AWAIT  = 3'd3;
  localparam logic [2:0] KIND_ADDR   = 3'd4;
  localparam logic [2:0] KIND_NONE   = 3'd5;

  localparam logic [2:0] SRC_PRODUCT = 3'd4;
  localparam logic [2:0] SRC_CODING  = 3'd6;
  localparam logic [2:0] DESC_COUNT  = 3'd6;
  localparam logic [6:0] CODING_LEN  = 7'd7;

  // Request codes.
  localparam logic [7:0] REQ_SET_ADDRESS     = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR  = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG      = 8'h09;
  localparam logic [7:0] REQ_SET_LINE_CODING = 8'h20;
  localparam logic [7:0] REQ_GET_LINE_CODING = 8'h21;
  localparam logic [7:0] REQ_SET_LINE_STATE  = 8'h22;

  // Request type bytes.
  localparam logic [7:0] RT_STD_OUT   = 8'h00;
  localparam logic [7:0] RT_STD_IN    = 8'h80;
  localparam logic [7:0] RT_CLASS_OUT = 8'h21;
  localparam logic [7:0] RT_CLASS_IN  = 8'ha1;

  localparam logic [6:0] PRODUCT_MIN = 7'd2;
  localparam logic [6:0] PRODUCT_MAX = 7'd64;

  // Micro-operations.
  localparam logic [1:0] OP_IDLE   = 2'd0;
  localparam logic [1:0] OP_DECODE = 2'd1;
  localparam logic [1:0] OP_CLIP   = 2'd2;
  localparam logic [1:0] OP_EMIT   = 2'd3;

  // Jump conditions.
  localparam logic [1:0] COND_NEVER      = 2'd0;
  localparam logic [1:0] COND_ACCEPT     = 2'd1;
  localparam logic [1:0] COND_LAST_TAKEN = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] cond;
    logic [1:0] target;
    logic       hold;
  } ucw_t;

  // Sequencer program: wait for a transaction, decode it, clip the length,
  // then emit results until the last one is taken.
  function automatic ucw_t ucode_rom(input logic [1:0] step);
    ucw_t w;
    unique case (step)
      2'd0:    w = '{op: OP_IDLE,   cond: COND_ACCEPT,     target: 2'd1, hold: 1'b1};
      2'd1:    w = '{op: OP_DECODE, cond: COND_NEVER,      target: 2'd0, hold: 1'b0};
      2'd2:    w = '{op: OP_CLIP,   cond: COND_NEVER,      target: 2'd0, hold: 1'b0};
      default: w = '{op: OP_EMIT,   cond: COND_LAST_TAKEN, target: 2'd0, hold: 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [15:0] desc_value(input logic [2:0] i);
    logic [15:0] v;
    unique case (i)
      3'd0:    v = 16'h0100;
      3'd1:    v = 16'h0200;
      3'd2:    v = 16'h0300;
      3'd3:    v = 16'h0301;
      3'd4:    v = 16'h0302;
      3'd5:    v = 16'h0303;
      default: v = 16'hffff;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] desc_index(input logic [2:0] i);
    logic [15:0] v;
    unique case (i)
      3'd0, 3'd1, 3'd2: v = 16'h0000;
      3'd3, 3'd4, 3'd5: v = 16'h0409;
      default:          v = 16'hffff;
    endcase
    return v;
  endfunction

  // The product string size comes from the register, not from this table.
  function automatic logic [6:0] desc_size(input logic [2:0] i);
    logic [6:0] v;
    unique case (i)
      3'd0:    v = 7'd18;
      3'd1:    v = 7'd62;
      3'd2:    v = 7'd4;
      3'd3:    v = 7'd38;
      3'd5:    v = 7'd10;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/usb_cdc_control_request_handler.sv
// CDC-ACM control endpoint request handler driven by a small microcoded sequencer.
// After the input transaction is accepted, the sequencer decodes it and clips the length before
// the first result is offered. Results then leave at one per cycle while out_stall is low, and no
// new request is taken until the last result has been taken, as set by the four-step sequencer program.
// Synchronous reset clears the step counter and the endpoint state, but not the latched request or
// the datapath registers; the product string length register resets to 2.
module usb_cdc_control_request_handler
  import ucdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] setup_value,
  input  logic [15:0] setup_index,
  input  logic [15:0] setup_length,
  input  logic [55:0] coding_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  reply_kind,
  output logic [2:0]  source_select,
  output logic [7:0]  byte_offset,
  output logic [6:0]  packet_bytes,
  output logic        last_of_run,
  output logic [6:0]  device_address,
  output logic        is_configured,
  output logic [7:0]  control_lines,
  output logic [55:0] coding_now
);

  logic [1:0]  pc;
  logic [1:0]  pc_next;
  ucw_t        ctrl;
  logic        in_take;
  logic        out_take;
  logic        cond_true;

  logic [6:0]  product_bytes;
  logic        configured_flag;
  logic [7:0]  line_state_reg;
  logic [55:0] coding_store;
  logic        await_coding;

  // Latched request.
  logic        req_func;
  logic [7:0]  req_type;
  logic [7:0]  req_code;
  logic [15:0] req_value;
  logic [15:0] req_index;
  logic [15:0] req_length;
  logic [55:0] req_coding;

  // Datapath registers.
  logic [2:0]  kind;
  logic [2:0]  sel;
  logic [6:0]  dsize;
  logic [6:0]  addr;
  logic [6:0]  rem;
  logic        zlp;
  logic [7:0]  off;

  // Decode results.
  logic [2:0]  dec_kind;
  logic [2:0]  dec_sel;
  logic [6:0]  dec_dsize;
  logic [6:0]  dec_addr;
  logic        dec_set_config;
  logic        dec_set_lines;
  logic        dec_set_coding;
  logic        dec_await;
  logic        desc_hit;
  logic [2:0]  desc_sel;
  logic [6:0]  desc_bytes;
  logic [6:0]  product_len;
  logic        idx_zero;
  logic        len_zero;

  logic [6:0]  xs;
  logic        emit_last;
  logic [15:0] dsize_wide;

  assign ctrl     = ucode_rom(pc);
  assign in_stall = (ctrl.op != OP_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_valid = (ctrl.op == OP_EMIT);
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    unique case (ctrl.cond)
      COND_ACCEPT:     cond_true = in_take;
      COND_LAST_TAKEN: cond_true = out_take && emit_last;
      default:         cond_true = 1'b0;
    endcase
    if (cond_true) begin
      pc_next = ctrl.target;
    end else if (ctrl.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + 2'd1;
    end
  end

  always_comb begin
    if (product_bytes < PRODUCT_MIN) begin
      product_len = PRODUCT_MIN;
    end else if (product_bytes > PRODUCT_MAX) begin
      product_len = PRODUCT_MAX;
    end else begin
      product_len = product_bytes;
    end
  end

  // Descriptor lookup over the six table entries.
  always_comb begin
    desc_hit   = 1'b0;
    desc_sel   = 3'd0;
    desc_bytes = 7'd0;
    for (int i = 0; i < DESC_COUNT; i++) begin
      if (req_value == desc_value(3'(i)) && req_index == desc_index(3'(i))) begin
        desc_hit   = 1'b1;
        desc_sel   = 3'(i);
        desc_bytes = (3'(i) == SRC_PRODUCT) ? product_len : desc_size(3'(i));
      end
    end
  end

  assign idx_zero = (req_index == 16'd0);
  assign len_zero = (req_length == 16'd0);

  always_comb begin
    dec_kind       = KIND_STALL;
    dec_sel        = 3'd0;
    dec_dsize      = 7'd0;
    dec_addr       = 7'd0;
    dec_set_config = 1'b0;
    dec_set_lines  = 1'b0;
    dec_set_coding = 1'b0;
    dec_await      = 1'b0;
    if (req_func) begin
      if (await_coding) begin
        dec_kind       = KIND_STATUS;
        dec_set_coding = 1'b1;
      end else begin
        dec_kind = KIND_NONE;
      end
    end else begin
      unique case (req_code)
        REQ_GET_DESCRIPTOR: begin
          if (req_type == RT_STD_IN && desc_hit) begin
            dec_kind  = KIND_DATA;
            dec_sel   = desc_sel;
            dec_dsize = desc_bytes;
          end
        end
        REQ_SET_ADDRESS: begin
          if (req_type == RT_STD_OUT && idx_zero && len_zero) begin
            dec_kind = KIND_ADDR;
            dec_addr = req_value[6:0];
          end
        end
        REQ_SET_CONFIG: begin
          if (req_type == RT_STD_OUT && req_value == 16'd1 && idx_zero && len_zero) begin
            dec_kind       = KIND_STATUS;
            dec_set_config = 1'b1;
          end
        end
        REQ_SET_LINE_CODING: begin
          if (req_type == RT_CLASS_OUT && req_value == 16'd0 && idx_zero &&
              req_length == {9'd0, CODING_LEN}) begin
            dec_kind  = KIND_AWAIT;
            dec_sel   = SRC_CODING;
            dec_await = 1'b1;
          end
        end
        REQ_GET_LINE_CODING: begin
          if (req_type == RT_CLASS_IN && req_value == 16'd0 && idx_zero &&
              req_length >= {9'd0, CODING_LEN}) begin
            dec_kind  = KIND_DATA;
            dec_sel   = SRC_CODING;
            dec_dsize = CODING_LEN;
          end
        end
        REQ_SET_LINE_STATE: begin
          if (req_type == RT_CLASS_OUT && idx_zero && len_zero) begin
            dec_kind      = KIND_STATUS;
            dec_set_lines = 1'b1;
          end
        end
        default: dec_kind = KIND_STALL;
      endcase
    end
  end

  // Packet split: a zero-length packet follows a full last packet when the
  // descriptor came up short of wLength.
  assign dsize_wide = {9'd0, dsize};
  assign xs         = (rem > EP0_PACKET_BYTES) ? EP0_PACKET_BYTES : rem;
  assign emit_last  = (rem <= EP0_PACKET_BYTES) && !(zlp && rem == EP0_PACKET_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc              <= 2'd0;
      product_bytes   <= PRODUCT_MIN;
      configured_flag <= 1'b0;
      line_state_reg  <= 8'd0;
      coding_store    <= 56'd0;
      await_coding    <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        product_bytes <= cfg_wdata;
      end
      if (ctrl.op == OP_DECODE) begin
        if (!req_func) begin
          await_coding <= dec_await;
        end else if (dec_set_coding) begin
          await_coding <= 1'b0;
        end
        if (dec_set_config) begin
          configured_flag <= 1'b1;
        end
        if (dec_set_lines) begin
          line_state_reg <= req_value[7:0];
        end
        if (dec_set_coding) begin
          coding_store <= req_coding;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_func   <= func;
      req_type   <= request_type;
      req_code   <= request_code;
      req_value  <= setup_value;
      req_index  <= setup_index;
      req_length <= setup_length;
      req_coding <= coding_bytes;
    end
    unique case (ctrl.op)
      OP_DECODE: begin
        kind  <= dec_kind;
        sel   <= dec_sel;
        dsize <= dec_dsize;
        addr  <= dec_addr;
        off   <= 8'd0;
      end
      OP_CLIP: begin
        if (dsize_wide > req_length) begin
          rem <= req_length[6:0];
          zlp <= 1'b0;
        end else begin
          rem <= dsize;
          zlp <= (dsize_wide < req_length) && (kind == KIND_DATA);
        end
      end
      OP_EMIT: begin
        if (out_take) begin
          off <= off + {1'b0, xs};
          rem <= rem - xs;
        end
      end
      default: begin
      end
    endcase
  end

  assign reply_kind     = kind;
  assign source_select  = sel;
  assign byte_offset    = off;
  assign packet_bytes   = xs;
  assign last_of_run    = emit_last;
  assign device_address = addr;
  assign is_configured  = configured_flag;
  assign control_lines  = line_state_reg;
  assign coding_now     = coding_store;

`ifndef SYNTHESIS
  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (pc == 2'd1))
    else $error("accepted transaction did not move to decode");

  a_packet_size: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (packet_bytes <= EP0_PACKET_BYTES))
    else $error("packet exceeds endpoint size");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reply_kind != KIND_DATA) |-> last_of_run)
    else $error("non-data reply is not the final result");

  a_offset_advance: assert property (@(posedge clk) disable iff (rst)
    (out_take && !last_of_run) |=>
      (out_valid && byte_offset == $past(byte_offset) + {1'b0, $past(packet_bytes)}))
    else $error("packet offset did not advance by the previous packet size");

  a_busy_while_emitting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while results are pending");
`endif

endmodule

>>> tb/tb_usb_cdc_control_request_handler.sv
// Self-checking testbench for the CDC control request handler, with its own reply predictor.
module tb_usb_cdc_control_request_handler;
  import ucdc_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int HOLD_OFF_CYCLES = 150;

  // Descriptor selectors, as they appear on source_select.
  localparam int SEL_DEVICE  = 0;
  localparam int SEL_CONFIG  = 1;
  localparam int SEL_LANGID  = 2;
  localparam int SEL_MAKER   = 3;
  localparam int SEL_PRODUCT = 4;
  localparam int SEL_SERIAL  = 5;
  localparam int SEL_MISSING = -1;

  // GET_DESCRIPTOR wValue and wIndex codes.
  localparam logic [15:0] WV_DEVICE  = 16'h0100;
  localparam logic [15:0] WV_CONFIG  = 16'h0200;
  localparam logic [15:0] WV_LANGID  = 16'h0300;
  localparam logic [15:0] WV_MAKER   = 16'h0301;
  localparam logic [15:0] WV_PRODUCT = 16'h0302;
  localparam logic [15:0] WV_SERIAL  = 16'h0303;
  localparam logic [15:0] NO_LANG    = 16'h0000;
  localparam logic [15:0] LANG_US    = 16'h0409;

  typedef struct packed {
    logic        func;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
    logic [55:0] coding;
  } ep0_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  src;
    logic [7:0]  offset;
    logic [6:0]  nbytes;
    logic        last;
    logic [6:0]  addr;
    logic        configured;
    logic [7:0]  lines;
    logic [55:0] coding;
  } ep0_reply_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] setup_value;
  logic [15:0] setup_index;
  logic [15:0] setup_length;
  logic [55:0] coding_bytes;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  reply_kind;
  logic [2:0]  source_select;
  logic [7:0]  byte_offset;
  logic [6:0]  packet_bytes;
  logic        last_of_run;
  logic [6:0]  device_address;
  logic        is_configured;
  logic [7:0]  control_lines;
  logic [55:0] coding_now;

  ep0_reply_t pending_replies[$];
  int mismatches;
  int tx_idle_pct;
  int rx_idle_pct;
  int holdoff_requests = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;

  // Predictor copy of the endpoint state and the product length register.
  logic [6:0]  pred_product;
  logic        pred_configured;
  logic [7:0]  pred_lines;
  logic [55:0] pred_coding;
  logic        pred_await;

  usb_cdc_control_request_handler u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .request_type   (request_type),
    .request_code   (request_code),
    .setup_value    (setup_value),
    .setup_index    (setup_index),
    .setup_length   (setup_length),
    .coding_bytes   (coding_bytes),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .reply_kind     (reply_kind),
    .source_select  (source_select),
    .byte_offset    (byte_offset),
    .packet_bytes   (packet_bytes),
    .last_of_run    (last_of_run),
    .device_address (device_address),
    .is_configured  (is_configured),
    .control_lines  (control_lines),
    .coding_now     (coding_now)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int descriptor_size(input int sel);
    case (sel)
      SEL_DEVICE: return 18;
      SEL_CONFIG: return 62;
      SEL_LANGID: return 4;
      SEL_MAKER:  return 38;
      SEL_SERIAL: return 10;
      default: begin
        if (pred_product < PRODUCT_MIN) return int'(PRODUCT_MIN);
        if (pred_product > PRODUCT_MAX) return int'(PRODUCT_MAX);
        return int'(pred_product);
      end
    endcase
  endfunction

  function automatic int find_descriptor(input logic [15:0] wv, input logic [15:0] wi);
    int sel;
    case (wv)
      WV_DEVICE:  sel = SEL_DEVICE;
      WV_CONFIG:  sel = SEL_CONFIG;
      WV_LANGID:  sel = SEL_LANGID;
      WV_MAKER:   sel = SEL_MAKER;
      WV_PRODUCT: sel = SEL_PRODUCT;
      WV_SERIAL:  sel = SEL_SERIAL;
      default:    return SEL_MISSING;
    endcase
    // String descriptors other than the language list want the US English index.
    if (wi != ((sel >= SEL_MAKER) ? LANG_US : NO_LANG)) return SEL_MISSING;
    return sel;
  endfunction

  task automatic push_reply(input logic [2:0] kind, input logic [2:0] src,
                            input logic [7:0] offset, input logic [6:0] nbytes,
                            input logic [6:0] addr);
    ep0_reply_t e;
    e.kind       = kind;
    e.src        = src;
    e.offset     = offset;
    e.nbytes     = nbytes;
    e.last       = 1'b0;
    e.addr       = addr;
    e.configured = pred_configured;
    e.lines      = pred_lines;
    e.coding     = pred_coding;
    pending_replies.push_back(e);
  endtask

  task automatic predict_ep0_replies(input ep0_req_t r);
    ep0_reply_t tail;
    int sel;
    int remain;
    int off;
    int chunk;
    int ep0;
    bit zlp;
    ep0 = int'(EP0_PACKET_BYTES);
    if (r.func) begin
      if (pred_await) begin
        pred_await  = 1'b0;
        pred_coding = r.coding;
        push_reply(KIND_STATUS, '0, '0, '0, '0);
      end else begin
        push_reply(KIND_NONE, '0, '0, '0, '0);
      end
    end else begin
      pred_await = 1'b0;
      case (r.code)
        REQ_GET_DESCRIPTOR: begin
          sel = find_descriptor(r.value, r.index);
          if (r.rtype != RT_STD_IN || sel == SEL_MISSING) begin
            push_reply(KIND_STALL, '0, '0, '0, '0);
          end else begin
            remain = descriptor_size(sel);
            zlp    = 1'b0;
            off    = 0;
            chunk  = 0;
            if (remain > r.length) remain = int'(r.length);
            else if (remain < r.length) zlp = 1'b1;
            // A zero wLength still produces one empty data packet.
            do begin
              chunk = (remain > ep0) ? ep0 : remain;
              push_reply(KIND_DATA, 3'(sel), 8'(off), 7'(chunk), '0);
              off    += chunk;
              remain -= chunk;
            end while (remain != 0);
            if (zlp && chunk == ep0) push_reply(KIND_DATA, 3'(sel), 8'(off), '0, '0);
          end
        end
        REQ_SET_ADDRESS:
          if (r.rtype == RT_STD_OUT && r.index == 0 && r.length == 0)
            push_reply(KIND_ADDR, '0, '0, '0, r.value[6:0]);
          else
            push_reply(KIND_STALL, '0, '0, '0, '0);
        REQ_SET_CONFIG:
          if (r.rtype == RT_STD_OUT && r.value == 1 && r.index == 0 && r.length == 0) begin
            pred_configured = 1'b1;
            push_reply(KIND_STATUS, '0, '0, '0, '0);
          end else begin
            push_reply(KIND_STALL, '0, '0, '0, '0);
          end
        REQ_SET_LINE_CODING:
          if (r.rtype == RT_CLASS_OUT && r.value == 0 && r.index == 0 &&
              r.length == CODING_LEN) begin
            pred_await = 1'b1;
            push_reply(KIND_AWAIT, SRC_CODING, '0, '0, '0);
          end else begin
            push_reply(KIND_STALL, '0, '0, '0, '0);
          end
        REQ_GET_LINE_CODING:
          if (r.rtype == RT_CLASS_IN && r.value == 0 && r.index == 0 &&
              r.length >= CODING_LEN)
            push_reply(KIND_DATA, SRC_CODING, '0, CODING_LEN, '0);
          else
            push_reply(KIND_STALL, '0, '0, '0, '0);
        REQ_SET_LINE_STATE:
          if (r.rtype == RT_CLASS_OUT && r.index == 0 && r.length == 0) begin
            pred_lines = r.value[7:0];
            push_reply(KIND_STATUS, '0, '0, '0, '0);
          end else begin
            push_reply(KIND_STALL, '0, '0, '0, '0);
          end
        default:
          push_reply(KIND_STALL, '0, '0, '0, '0);
      endcase
    end
    tail = pending_replies.pop_back();
    tail.last = 1'b1;
    pending_replies.push_back(tail);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_replies
    ep0_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply of kind %0d", reply_kind));
      end else begin
        want = pending_replies.pop_front();
        check_field("reply_kind", 64'(reply_kind), 64'(want.kind));
        check_field("source_select", 64'(source_select), 64'(want.src));
        check_field("byte_offset", 64'(byte_offset), 64'(want.offset));
        check_field("packet_bytes", 64'(packet_bytes), 64'(want.nbytes));
        check_field("last_of_run", 64'(last_of_run), 64'(want.last));
        check_field("device_address", 64'(device_address), 64'(want.addr));
        check_field("is_configured", 64'(is_configured), 64'(want.configured));
        check_field("control_lines", 64'(control_lines), 64'(want.lines));
        check_field("coding_now", 64'(coding_now), 64'(want.coding));
      end
    end
  end

  // The run is stuck if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (holdoff_seen != holdoff_requests) begin
      holdoff_seen = holdoff_requests;
      holdoff_left = HOLD_OFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic ep0_req_t setup_req(input logic [7:0] rt, input logic [7:0] code,
                                         input logic [15:0] val, input logic [15:0] idx,
                                         input logic [15:0] len);
    ep0_req_t r;
    r.func   = 1'b0;
    r.rtype  = rt;
    r.code   = code;
    r.value  = val;
    r.index  = idx;
    r.length = len;
    r.coding = 56'({$urandom, $urandom});
    return r;
  endfunction

  // Line coding data stage; the setup fields ride along with random content.
  function automatic ep0_req_t data_req(input logic [55:0] coding);
    ep0_req_t r;
    r = setup_req(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    r.func   = 1'b1;
    r.coding = coding;
    return r;
  endfunction

  function automatic logic [15:0] pick_length(input int dsize);
    case ($urandom_range(6))
      0:       return 16'd0;
      1:       return 16'($urandom_range(1, 80));
      2:       return 16'(dsize);
      3:       return 16'(dsize + 1);
      4:       return 16'((dsize > 0) ? dsize - 1 : 0);
      5:       return 16'(8 * $urandom_range(1, 9));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ep0_req_t well_formed_setup(input int which);
    int sel;
    logic [15:0] wv;
    case (which)
      0: begin
        sel = $urandom_range(SEL_SERIAL);
        case (sel)
          SEL_DEVICE:  wv = WV_DEVICE;
          SEL_CONFIG:  wv = WV_CONFIG;
          SEL_LANGID:  wv = WV_LANGID;
          SEL_MAKER:   wv = WV_MAKER;
          SEL_PRODUCT: wv = WV_PRODUCT;
          default:     wv = WV_SERIAL;
        endcase
        return setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, wv,
                         (sel >= SEL_MAKER) ? LANG_US : NO_LANG,
                         pick_length(descriptor_size(sel)));
      end
      1: return setup_req(RT_STD_OUT, REQ_SET_ADDRESS, 16'($urandom), 16'd0, 16'd0);
      2: return setup_req(RT_STD_OUT, REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0);
      3: return setup_req(RT_CLASS_OUT, REQ_SET_LINE_CODING, 16'd0, 16'd0, 16'(CODING_LEN));
      4: return setup_req(RT_CLASS_IN, REQ_GET_LINE_CODING, 16'd0, 16'd0,
                          $urandom_range(1) ? 16'(CODING_LEN) : 16'($urandom_range(7, 65535)));
      default:
        return setup_req(RT_CLASS_OUT, REQ_SET_LINE_STATE, 16'($urandom), 16'd0, 16'd0);
    endcase
  endfunction

  task automatic send_item(input ep0_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    func         <= r.func;
    request_type <= r.rtype;
    request_code <= r.code;
    setup_value  <= r.value;
    setup_index  <= r.index;
    setup_length <= r.length;
    coding_bytes <= r.coding;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_ep0_replies(r);
  endtask

  task automatic quiet_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain(input int settle);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_product_length(input logic [6:0] v);
    quiet_input();
    wait_for_drain(3);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    pred_product = v;
  endtask

  // Most traffic is well-formed; the rest is corrupted or plain noise.
  task automatic send_random_transaction(output int n_items);
    ep0_req_t r;
    int pick;
    int bitpos;
    pick    = $urandom_range(99);
    n_items = 1;
    if (pick < 35) begin
      send_item(well_formed_setup(0));
    end else if (pick < 50) begin
      send_item(well_formed_setup(3));
      // Now and then another setup cuts in; unless it is itself a line coding request, the data stage is then ignored.
      if ($urandom_range(9) == 0) begin
        send_item(well_formed_setup($urandom_range(5)));
        n_items++;
      end
      send_item(data_req(56'({$urandom, $urandom})));
      n_items++;
    end else if (pick < 70) begin
      send_item(well_formed_setup($urandom_range(1, 5)));
    end else if (pick < 85) begin
      r      = well_formed_setup($urandom_range(5));
      bitpos = $urandom_range(15);
      case ($urandom_range(4))
        0:       r.rtype[bitpos % 8] = ~r.rtype[bitpos % 8];
        1:       r.code[bitpos % 8]  = ~r.code[bitpos % 8];
        2:       r.value[bitpos]     = ~r.value[bitpos];
        3:       r.index[bitpos]     = ~r.index[bitpos];
        default: r.length[bitpos]    = ~r.length[bitpos];
      endcase
      send_item(r);
    end else if (pick < 93) begin
      send_item(setup_req(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom)));
    end else begin
      send_item(data_req(56'({$urandom, $urandom})));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_descriptor_replies();
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_DEVICE, NO_LANG, 16'hFFFF));
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_CONFIG, NO_LANG, 16'hFFFF));
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_LANGID, NO_LANG, 16'd0));
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_MAKER, LANG_US, 16'd40));
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_SERIAL, LANG_US, 16'd8));
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_PRODUCT, LANG_US, 16'hFFFF));
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_DEVICE, NO_LANG, 16'd16));
    send_item(setup_req(RT_STD_OUT, REQ_GET_DESCRIPTOR, WV_DEVICE, NO_LANG, 16'd18));
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, 16'h0304, LANG_US, 16'd18));
    quiet_input();
  endtask

  // Product string length at the top of its range and beyond both ends; the register is then set back to the minimum.
  task automatic test_product_length();
    write_product_length(PRODUCT_MAX);
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_PRODUCT, LANG_US, 16'hFFFF));
    write_product_length(7'h7F);
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_PRODUCT, LANG_US, 16'd65));
    write_product_length(7'd0);
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_PRODUCT, LANG_US, 16'd8));
    write_product_length(PRODUCT_MIN);
    send_item(setup_req(RT_STD_IN, REQ_GET_DESCRIPTOR, WV_SERIAL, LANG_US, 16'd16));
    quiet_input();
  endtask

  task automatic test_standard_requests();
    send_item(setup_req(RT_STD_OUT, REQ_SET_ADDRESS, 16'hFFFF, 16'd0, 16'd0));
    send_item(setup_req(RT_STD_OUT, REQ_SET_ADDRESS, 16'd5, 16'd1, 16'd0));
    send_item(setup_req(RT_STD_OUT, REQ_SET_CONFIG, 16'd0, 16'd0, 16'd0));
    send_item(setup_req(RT_STD_OUT, REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0));
    quiet_input();
  endtask

  task automatic test_line_requests();
    send_item(setup_req(RT_CLASS_OUT, REQ_SET_LINE_STATE, 16'hFF03, 16'd0, 16'd0));
    send_item(setup_req(RT_CLASS_OUT, REQ_SET_LINE_CODING, 16'd0, 16'd0, 16'(CODING_LEN)));
    send_item(data_req('1));
    send_item(setup_req(RT_CLASS_IN, REQ_GET_LINE_CODING, 16'd0, 16'd0, 16'(CODING_LEN)));
    send_item(setup_req(RT_CLASS_IN, REQ_GET_LINE_CODING, 16'd0, 16'd0, 16'd6));
    send_item(data_req('0));
    // A setup arriving while the data stage is pending cancels it.
    send_item(setup_req(RT_CLASS_OUT, REQ_SET_LINE_CODING, 16'd0, 16'd0, 16'(CODING_LEN)));
    send_item(setup_req(RT_CLASS_IN, REQ_GET_LINE_CODING, 16'd0, 16'd0, 16'hFFFF));
    send_item(data_req('0));
    send_item(setup_req(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    quiet_input();
  endtask

  task automatic test_random_traffic(input int count);
    int sent;
    int n;
    sent = 0;
    while (sent < count) begin
      send_random_transaction(n);
      sent += n;
    end
    quiet_input();
  endtask

  // The receiver holds off while requests keep coming, so the input backs up.
  task automatic test_backpressure();
    int saved_idle;
    int n;
    saved_idle  = tx_idle_pct;
    tx_idle_pct = 0;
    holdoff_requests++;
    repeat (12) send_random_transaction(n);
    quiet_input();
    tx_idle_pct = saved_idle;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = PRODUCT_MIN;
    in_valid     = 1'b0;
    func         = 1'b0;
    request_type = '0;
    request_code = '0;
    setup_value  = '0;
    setup_index  = '0;
    setup_length = '0;
    coding_bytes = '0;
    mismatches   = 0;
    tx_idle_pct  = 14;
    rx_idle_pct  = 52;

    pred_product    = PRODUCT_MIN;
    pred_configured = 1'b0;
    pred_lines      = '0;
    pred_coding     = '0;
    pred_await      = 1'b0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_descriptor_replies();
    test_product_length();
    test_standard_requests();
    test_line_requests();
    test_random_traffic(40);

    write_product_length(7'($urandom));
    tx_idle_pct = 52;
    rx_idle_pct = 14;
    test_random_traffic(35);
    test_backpressure();

    write_product_length(7'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(40);

    wait_for_drain(12);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ucdc_pkg.sv
rtl/core/usb_cdc_control_request_handler.sv
tb/tb_usb_cdc_control_request_handler.sv
